// ===== rtl/dda_pkg.sv =====
// dda_pkg: widths, queue entry and status types, back-end state codes
// for the dda line rasterizer; no dependencies

package dda_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_W     = FRAC_BITS + 2;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   is_step;
    logic   x_major;
    coord_t major_start;
    coord_t major_end;
    coord_t minor_start;
    coord_t major_delta;
    coord_t minor_mag;
    logic   minor_neg;
  } dda_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dda_qstat_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } dda_bk_state_t;

endpackage

// ===== rtl/dda_if.sv =====
// dda_in_if, dda_out_if: valid/ready channels for requests and pixels
// depends on dda_pkg for coordinate width

interface dda_in_if import dda_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_out_if import dda_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ===== rtl/dda_front.sv =====
// dda_front: accepts request transactions, orders endpoints and picks the
// major axis; depends on dda_pkg and dda_in_if

module dda_front import dda_pkg::*; (
  dda_in_if.sink     in_ch,
  input  dda_qstat_t qstat,
  output logic       push,
  output dda_entry_t push_entry
);

  coord_t adx;
  coord_t ady;
  logic   swap_x;
  logic   swap_y;
  logic   x_major;
  coord_t a0;
  coord_t a1;
  coord_t b0;
  coord_t b1;

  always_comb begin
    swap_x  = in_ch.start_x > in_ch.end_x;
    swap_y  = in_ch.start_y > in_ch.end_y;
    adx     = swap_x ? in_ch.start_x - in_ch.end_x : in_ch.end_x - in_ch.start_x;
    ady     = swap_y ? in_ch.start_y - in_ch.end_y : in_ch.end_y - in_ch.start_y;
    x_major = ady < adx;
    if (x_major) begin
      a0 = swap_x ? in_ch.end_x : in_ch.start_x;
      a1 = swap_x ? in_ch.start_x : in_ch.end_x;
      b0 = swap_x ? in_ch.end_y : in_ch.start_y;
      b1 = swap_x ? in_ch.start_y : in_ch.end_y;
    end else begin
      a0 = swap_y ? in_ch.end_y : in_ch.start_y;
      a1 = swap_y ? in_ch.start_y : in_ch.end_y;
      b0 = swap_y ? in_ch.end_x : in_ch.start_x;
      b1 = swap_y ? in_ch.start_x : in_ch.end_x;
    end
    push_entry.is_step     = in_ch.req_type == REQ_STEP;
    push_entry.x_major     = x_major;
    push_entry.major_start = a0;
    push_entry.major_end   = a1;
    push_entry.minor_start = b0;
    push_entry.major_delta = x_major ? adx : ady;
    push_entry.minor_mag   = x_major ? ady : adx;
    push_entry.minor_neg   = b0 > b1;
  end

  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && !qstat.full;

endmodule

// ===== rtl/dda_queue.sv =====
// dda_queue: short fifo of classified requests between front and back
// depends on dda_pkg

module dda_queue import dda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dda_entry_t push_entry,
  input  logic       pop,
  output dda_entry_t head,
  output dda_qstat_t qstat
);

  dda_entry_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r;
  logic [QPTR_W-1:0]       wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r;
  logic [QPTR_W-1:0]       rd_ptr_nxt;
  logic [QCNT_W-1:0]       cnt_r;
  logic [QCNT_W-1:0]       cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head        = slot_r[rd_ptr_r];
  assign qstat.full  = cnt_r == QCNT_W'(QDEPTH);
  assign qstat.empty = cnt_r == '0;

endmodule

// ===== rtl/dda_back.sv =====
// dda_back: line state, iterative slope divider and pixel output register
// depends on dda_pkg and dda_out_if

module dda_back import dda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dda_entry_t head,
  input  dda_qstat_t qstat,
  output logic       pop,
  dda_out_if.source  out_ch
);

  dda_bk_state_t          state_r;
  dda_bk_state_t          state_nxt;
  logic                   line_active_r;
  logic                   line_active_nxt;
  logic                   x_major_r;
  logic                   x_major_nxt;
  coord_t                 major_pos_r;
  coord_t                 major_pos_nxt;
  coord_t                 major_end_r;
  coord_t                 major_end_nxt;
  logic [ACC_W-1:0]       minor_acc_r;
  logic [ACC_W-1:0]       minor_acc_nxt;
  logic [STEP_W-1:0]      minor_step_r;
  logic [STEP_W-1:0]      minor_step_nxt;
  coord_t                 rem_r;
  coord_t                 rem_nxt;
  coord_t                 den_r;
  coord_t                 den_nxt;
  logic [QUO_W-1:0]       quo_r;
  logic [QUO_W-1:0]       quo_nxt;
  logic                   neg_r;
  logic                   neg_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [DIV_CNT_W-1:0]   cnt_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  coord_t                 pixel_x_r;
  coord_t                 pixel_x_nxt;
  coord_t                 pixel_y_r;
  coord_t                 pixel_y_nxt;
  logic                   last_r;
  logic                   last_nxt;

  logic                   slot_free;
  logic                   emit;
  logic                   last;
  logic [ACC_W-1:0]       round_sum;
  coord_t                 minor;
  logic [COORD_BITS:0]    trial;
  logic                   ge;
  logic [STEP_W-1:0]      step_mag;

  always_comb begin
    slot_free = !out_valid_r || out_ch.ready;
    round_sum = minor_acc_r + (ACC_W'(1) << (FRAC_BITS - 1));
    minor     = round_sum[FRAC_BITS +: COORD_BITS];
    last      = major_pos_r == major_end_r;
    trial     = (cnt_r == DIV_CNT_W'(FRAC_BITS)) ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge        = trial >= {1'b0, den_r};

    state_nxt       = state_r;
    line_active_nxt = line_active_r;
    x_major_nxt     = x_major_r;
    major_pos_nxt   = major_pos_r;
    major_end_nxt   = major_end_r;
    minor_acc_nxt   = minor_acc_r;
    minor_step_nxt  = minor_step_r;
    rem_nxt         = rem_r;
    den_nxt         = den_r;
    quo_nxt         = quo_r;
    neg_nxt         = neg_r;
    cnt_nxt         = cnt_r;
    pixel_x_nxt     = pixel_x_r;
    pixel_y_nxt     = pixel_y_r;
    last_nxt        = last_r;
    pop             = 1'b0;
    emit            = 1'b0;
    step_mag        = '0;

    case (state_r)
      BK_RUN: begin
        if (!qstat.empty) begin
          if (head.is_step) begin
            if (!line_active_r) begin
              pop = 1'b1;
            end else if (slot_free) begin
              pop         = 1'b1;
              emit        = 1'b1;
              pixel_x_nxt = x_major_r ? major_pos_r : minor;
              pixel_y_nxt = x_major_r ? minor : major_pos_r;
              last_nxt    = last;
              if (last) begin
                line_active_nxt = 1'b0;
              end else begin
                major_pos_nxt = major_pos_r + COORD_BITS'(1);
                minor_acc_nxt = minor_acc_r
                              + {{(ACC_W-STEP_W){minor_step_r[STEP_W-1]}}, minor_step_r};
              end
            end
          end else begin
            pop             = 1'b1;
            line_active_nxt = 1'b1;
            x_major_nxt     = head.x_major;
            major_pos_nxt   = head.major_start;
            major_end_nxt   = head.major_end;
            minor_acc_nxt   = {1'b0, head.minor_start, {FRAC_BITS{1'b0}}};
            if (head.major_delta == '0) begin
              minor_step_nxt = '0;
            end else begin
              state_nxt = BK_DIV;
              rem_nxt   = head.minor_mag;
              den_nxt   = head.major_delta;
              neg_nxt   = head.minor_neg;
              quo_nxt   = '0;
              cnt_nxt   = DIV_CNT_W'(FRAC_BITS);
            end
          end
        end
      end
      BK_DIV: begin
        rem_nxt = ge ? COORD_BITS'(trial - {1'b0, den_r}) : COORD_BITS'(trial);
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        if (cnt_r == '0) begin
          step_mag       = {1'b0, quo_nxt};
          minor_step_nxt = neg_r ? STEP_W'(0) - step_mag : step_mag;
          state_nxt      = BK_RUN;
        end else begin
          cnt_nxt = cnt_r - DIV_CNT_W'(1);
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_RUN;
      line_active_r <= 1'b0;
      x_major_r     <= 1'b0;
      major_pos_r   <= '0;
      major_end_r   <= '0;
      minor_acc_r   <= '0;
      minor_step_r  <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      line_active_r <= line_active_nxt;
      x_major_r     <= x_major_nxt;
      major_pos_r   <= major_pos_nxt;
      major_end_r   <= major_end_nxt;
      minor_acc_r   <= minor_acc_nxt;
      minor_step_r  <= minor_step_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    quo_r     <= quo_nxt;
    neg_r     <= neg_nxt;
    pixel_x_r <= pixel_x_nxt;
    pixel_y_r <= pixel_y_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = pixel_x_r;
  assign out_ch.pixel_y    = pixel_y_r;
  assign out_ch.last_pixel = last_r;

`ifndef SYNTHESIS
  a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> !pop)
    else $error("queue popped during slope division");

  a_emit_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> line_active_r && !qstat.empty && head.is_step)
    else $error("pixel emitted without an active line");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    emit && last |=> !line_active_r && out_ch.valid && out_ch.last_pixel)
    else $error("line still active after its last pixel");

  a_div_returns: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV && cnt_r == '0 |=> state_r == BK_RUN)
    else $error("divider did not finish");
`endif

endmodule

// ===== rtl/dda_line_rasterizer_core.sv =====
// dda_line_rasterizer_core: top level, front classifier, request queue and
// back end; depends on dda_pkg, dda_if, dda_front, dda_queue, dda_back
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  req_type, start_x, start_y, end_x, end_y
//   out_ch   out  valid/ready  pixel_x, pixel_y, last_pixel
//
// step transaction: one pixel, emitted when the output register is free; then the minor accumulator add
// load transaction: loads the line state, then runs the bit-serial slope divider
//   when the major delta is nonzero; later steps wait in the queue
// a step with no active line is dropped without a pixel
// reset: synchronous, clears queue, line state and output valid
// a stalled out_ch holds the pixel register; the two-entry queue fills and
//   in_ch.ready drops

module dda_line_rasterizer_core import dda_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dda_in_if.sink    in_ch,
  dda_out_if.source out_ch
);

  logic       push;
  logic       pop;
  dda_entry_t push_entry;
  dda_entry_t head;
  dda_qstat_t qstat;

  dda_front u_front (
    .in_ch      (in_ch),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  dda_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  dda_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
